[design/unimodular_basis_completion_core_macros.svh]
// Assertion macros used by the unimodular basis completion core.
`ifndef UNIMODULAR_BASIS_COMPLETION_CORE_MACROS_SVH
`define UNIMODULAR_BASIS_COMPLETION_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define UBC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed in unimodular_basis_completion_core");
`define UBC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed in unimodular_basis_completion_core");
`else
`define UBC_ASSERT_SAME(label, clk, rstn, ante, cons)
`define UBC_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

[design/ubc_pkg.sv]
// Types and constants of the unimodular basis completion core.
package ubc_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_WIDTH  = $clog2(DATA_WIDTH);

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] first_value;
        logic signed [DATA_WIDTH-1:0] second_value;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] coef_c;
        logic signed [DATA_WIDTH-1:0] coef_d;
        logic                         status;
    } out_word_t;

    localparam logic STATUS_OK            = 1'b0;
    localparam logic STATUS_NOT_PRIMITIVE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_UPDATE,
        ST_FINISH
    } state_t;

endpackage

[design/unimodular_basis_completion_core.sv]
// After an input word is accepted, ST_CHECK, ST_DIV and ST_UPDATE repeat once per Euclid step
// until the remainder is zero; ST_FINISH then registers the result and raises m_valid.
// The shared restoring divider produces one quotient bit per cycle.
// s_ready comes back with m_valid, so a new word is taken only once the previous result is registered.
// Reset (aresetn low, synchronous) returns the sequencer to idle and drops m_valid.
`include "unimodular_basis_completion_core_macros.svh"

module unimodular_basis_completion_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ubc_pkg::in_word_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ubc_pkg::out_word_t  m_data
);
    import ubc_pkg::*;

    localparam int W = DATA_WIDTH;

    state_t                state_reg, state_next;
    logic                  m_valid_reg, m_valid_next;
    out_word_t             m_data_reg, m_data_next;

    logic                  pr_sign_reg, pr_sign_next;
    logic                  cr_sign_reg, cr_sign_next;
    logic [W-1:0]          pr_mag_reg, pr_mag_next;
    logic [W-1:0]          cr_mag_reg, cr_mag_next;
    logic [W-1:0]          px_reg, px_next, cx_reg, cx_next;
    logic [W-1:0]          py_reg, py_next, cy_reg, cy_next;
    logic [W-1:0]          rem_reg, rem_next;
    logic [W-1:0]          num_reg, num_next;
    logic [W-1:0]          accx_reg, accx_next, accy_reg, accy_next;
    logic [CNT_WIDTH-1:0]  cnt_reg, cnt_next;

    logic [W:0]            shifted;
    logic [W:0]            diff;
    logic                  take;
    logic                  q_neg;
    logic [W-1:0]          a_bits, b_bits;
    logic [W-1:0]          fx, fy;
    logic                  div_phase;
    logic                  err_word;
    logic                  err_zero;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // One restoring division step; the quotient bit also drives the Horner
    // accumulation of |q|*cx and |q|*cy, so no multiplier is needed.
    assign shifted = {rem_reg, num_reg[W-1]};
    assign diff    = shifted - {1'b0, cr_mag_reg};
    assign take    = ~diff[W];
    assign q_neg   = pr_sign_reg ^ cr_sign_reg;

    assign a_bits  = s_data.first_value;
    assign b_bits  = s_data.second_value;

    // A last remainder of -1 flips the sign of both coefficients.
    assign fx = pr_sign_reg ? (W'(0) - px_reg) : px_reg;
    assign fy = pr_sign_reg ? (W'(0) - py_reg) : py_reg;

    assign div_phase = (state_reg == ST_DIV) || (state_reg == ST_UPDATE);
    assign err_word  = m_valid_reg && (m_data_reg.status == STATUS_NOT_PRIMITIVE);
    assign err_zero  = (m_data_reg.coef_c == W'(0)) && (m_data_reg.coef_d == W'(0));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg  <= m_data_next;
        pr_sign_reg <= pr_sign_next;
        cr_sign_reg <= cr_sign_next;
        pr_mag_reg  <= pr_mag_next;
        cr_mag_reg  <= cr_mag_next;
        px_reg      <= px_next;
        cx_reg      <= cx_next;
        py_reg      <= py_next;
        cy_reg      <= cy_next;
        rem_reg     <= rem_next;
        num_reg     <= num_next;
        accx_reg    <= accx_next;
        accy_reg    <= accy_next;
        cnt_reg     <= cnt_next;
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        pr_sign_next = pr_sign_reg;
        cr_sign_next = cr_sign_reg;
        pr_mag_next  = pr_mag_reg;
        cr_mag_next  = cr_mag_reg;
        px_next      = px_reg;
        cx_next      = cx_reg;
        py_next      = py_reg;
        cy_next      = cy_reg;
        rem_next     = rem_reg;
        num_next     = num_reg;
        accx_next    = accx_reg;
        accy_next    = accy_reg;
        cnt_next     = cnt_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    pr_sign_next = a_bits[W-1];
                    pr_mag_next  = a_bits[W-1] ? (W'(0) - a_bits) : a_bits;
                    cr_sign_next = b_bits[W-1];
                    cr_mag_next  = b_bits[W-1] ? (W'(0) - b_bits) : b_bits;
                    px_next      = W'(1);
                    cx_next      = W'(0);
                    py_next      = W'(0);
                    cy_next      = W'(1);
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (cr_mag_reg == W'(0)) begin
                    state_next = ST_FINISH;
                end else begin
                    rem_next   = W'(0);
                    num_next   = pr_mag_reg;
                    accx_next  = W'(0);
                    accy_next  = W'(0);
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next  = take ? diff[W-1:0] : shifted[W-1:0];
                num_next  = {num_reg[W-2:0], 1'b0};
                accx_next = {accx_reg[W-2:0], 1'b0} + (take ? cx_reg : W'(0));
                accy_next = {accy_reg[W-2:0], 1'b0} + (take ? cy_reg : W'(0));
                cnt_next  = cnt_reg + CNT_WIDTH'(1);
                if (cnt_reg == CNT_WIDTH'(W - 1)) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // The truncated remainder carries the sign of the dividend.
                pr_sign_next = cr_sign_reg;
                pr_mag_next  = cr_mag_reg;
                cr_sign_next = pr_sign_reg;
                cr_mag_next  = rem_reg;
                px_next      = cx_reg;
                py_next      = cy_reg;
                cx_next      = q_neg ? (px_reg + accx_reg) : (px_reg - accx_reg);
                cy_next      = q_neg ? (py_reg + accy_reg) : (py_reg - accy_reg);
                state_next   = ST_CHECK;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if (pr_mag_reg == W'(1)) begin
                        m_data_next.coef_c = W'(0) - fy;
                        m_data_next.coef_d = fx;
                        m_data_next.status = STATUS_OK;
                    end else begin
                        m_data_next.coef_c = '0;
                        m_data_next.coef_d = '0;
                        m_data_next.status = STATUS_NOT_PRIMITIVE;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `UBC_ASSERT_SAME(a_div_nonzero, aclk, aresetn, state_reg == ST_DIV, cr_mag_reg != W'(0))
    `UBC_ASSERT_SAME(a_rem_below_div, aclk, aresetn, div_phase, rem_reg < cr_mag_reg)
    `UBC_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `UBC_ASSERT_SAME(a_error_zero, aclk, aresetn, err_word, err_zero)

endmodule

[tb/sv/tb_unimodular_basis_completion_core.sv]
// Self-checking testbench for the unimodular basis completion core.
`timescale 1ns / 100ps

module tb_unimodular_basis_completion_core;
    import ubc_pkg::*;

    localparam int HOLD_CYCLES  = 5000;
    localparam int SETTLE_CYCLES = 1800;
    localparam logic signed [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    out_word_t expected_bases[$];
    out_word_t want;
    int        error_count = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_requests = 0;

    unimodular_basis_completion_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Extended Euclid on sign-extended 64-bit values, quotients truncated toward zero.
    function automatic out_word_t complete_basis(input in_word_t w);
        logic signed [63:0] r_prev, r_cur, x_prev, x_cur, y_prev, y_cur, q, t;
        out_word_t res;
        r_prev = {{(64-DATA_WIDTH){w.first_value[DATA_WIDTH-1]}}, w.first_value};
        r_cur  = {{(64-DATA_WIDTH){w.second_value[DATA_WIDTH-1]}}, w.second_value};
        x_prev = 64'sd1;
        x_cur  = 64'sd0;
        y_prev = 64'sd0;
        y_cur  = 64'sd1;
        while (r_cur != 0) begin
            q = r_prev / r_cur;
            t = r_prev - q * r_cur;
            r_prev = r_cur;
            r_cur = t;
            t = x_prev - q * x_cur;
            x_prev = x_cur;
            x_cur = t;
            t = y_prev - q * y_cur;
            y_prev = y_cur;
            y_cur = t;
        end
        if (r_prev != 64'sd1 && r_prev != -64'sd1) begin
            res.coef_c = '0;
            res.coef_d = '0;
            res.status = STATUS_NOT_PRIMITIVE;
        end else begin
            if (r_prev == -64'sd1) begin
                x_prev = -x_prev;
                y_prev = -y_prev;
            end
            t = -y_prev;
            res.coef_c = t[DATA_WIDTH-1:0];
            res.coef_d = x_prev[DATA_WIDTH-1:0];
            res.status = STATUS_OK;
        end
        return res;
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] signed_small(input int unsigned lim);
        logic signed [DATA_WIDTH-1:0] mag;
        mag = $urandom_range(lim);
        return $urandom_range(1) ? -mag : mag;
    endfunction

    // Consecutive Fibonacci numbers give the longest run of Euclid steps.
    function automatic in_word_t fib_pair(input int n);
        logic signed [63:0] lo, hi, t;
        in_word_t w;
        lo = 64'sd1;
        hi = 64'sd1;
        for (int i = 1; i < n; i++) begin
            t = hi + lo;
            lo = hi;
            hi = t;
        end
        w.first_value  = hi[DATA_WIDTH-1:0];
        w.second_value = lo[DATA_WIDTH-1:0];
        return w;
    endfunction

    function automatic in_word_t random_pair();
        in_word_t w;
        int unsigned pick;
        int k;
        logic signed [DATA_WIDTH-1:0] tmp;
        pick = $urandom_range(99);
        if (pick < 40) begin
            w.first_value  = $urandom;
            w.second_value = $urandom;
        end else if (pick < 60) begin
            w.first_value  = signed_small(200);
            w.second_value = signed_small(200);
        end else if (pick < 75) begin
            // A common factor of at least two makes the pair not primitive.
            k = $urandom_range(2, 1000);
            w.first_value  = k * signed_small(1000000);
            w.second_value = k * signed_small(1000000);
        end else if (pick < 85) begin
            w = fib_pair($urandom_range(1, 45));
            if ($urandom_range(1)) w.first_value = -w.first_value;
            if ($urandom_range(1)) w.second_value = -w.second_value;
            if ($urandom_range(1)) begin
                tmp = w.first_value;
                w.first_value = w.second_value;
                w.second_value = tmp;
            end
        end else if (pick < 90) begin
            tmp = $urandom_range(1) ? signed_small(1) : $urandom;
            if ($urandom_range(1)) begin
                w.first_value  = tmp;
                w.second_value = '0;
            end else begin
                w.first_value  = '0;
                w.second_value = tmp;
            end
        end else begin
            w.first_value  = signed_small(32'h3fff_ffff);
            w.second_value = $urandom_range(1) ? w.first_value + 1 : w.first_value - 1;
        end
        if (w.first_value == MIN_VAL) w.first_value = MIN_VAL + 1;
        if (w.second_value == MIN_VAL) w.second_value = MIN_VAL + 1;
        return w;
    endfunction

    // Offers one word; valid stays up with the same payload until it is taken.
    task automatic offer_pair(input logic signed [DATA_WIDTH-1:0] a,
                              input logic signed [DATA_WIDTH-1:0] b);
        in_word_t w;
        w.first_value  = a;
        w.second_value = b;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_bases.insert(expected_bases.size(), complete_basis(w));
    endtask

    task automatic await_results();
        s_valid <= 1'b0;
        while (expected_bases.size() != 0) @(posedge aclk);
    endtask

    task automatic send_random(input int count);
        in_word_t w;
        for (int i = 0; i < count; i++) begin
            w = random_pair();
            offer_pair(w.first_value, w.second_value);
        end
        await_results();
    endtask

    task automatic test_directed();
        in_word_t f;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        offer_pair(0, 0);
        offer_pair(1, 0);
        offer_pair(0, 1);
        offer_pair(-1, 0);
        offer_pair(0, -1);
        offer_pair(1, 1);
        offer_pair(-1, -1);
        offer_pair(MAX_VAL, MAX_VAL - 1);
        offer_pair(MAX_VAL, MAX_VAL);
        offer_pair(MAX_VAL, 1);
        offer_pair(-MAX_VAL, MAX_VAL);
        offer_pair(MAX_VAL, -1);
        offer_pair(2, 4);
        offer_pair(3, 5);
        offer_pair(-7, 3);
        offer_pair(6, -4);
        f = fib_pair(45);
        offer_pair(f.first_value, f.second_value);
        offer_pair(-f.first_value, f.second_value);
        // The most negative value lies outside the nominal range but is still defined.
        offer_pair(MIN_VAL, 1);
        offer_pair(1, MIN_VAL);
        offer_pair(MIN_VAL, 0);
        offer_pair(0, MIN_VAL);
        offer_pair(MIN_VAL, MIN_VAL + 1);
        await_results();
    endtask

    task automatic test_streaming();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random(85);
    endtask

    task automatic test_sender_gaps();
        send_idle_pct  = 64;
        recv_stall_pct = 0;
        send_random(84);
    endtask

    task automatic test_receiver_stalls();
        send_idle_pct  = 0;
        recv_stall_pct = 64;
        send_random(84);
    endtask

    task automatic test_mixed_idling();
        send_idle_pct  = 29;
        recv_stall_pct = 29;
        send_random(84);
    endtask

    // The receiver holds off long enough that the core stalls its input.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests++;
        send_random(10);
    endtask

    initial begin : receiver
        int hold_served;
        hold_served = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                for (int n = 0; n < HOLD_CYCLES; n++) begin
                    m_ready <= 1'b0;
                    @(posedge aclk);
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_bases.size() == 0) begin
                $error("result word with no expected entry: c=%0d d=%0d status=%0b",
                       m_data.coef_c, m_data.coef_d, m_data.status);
                error_count++;
            end else begin
                want = expected_bases.pop_front();
                if (m_data.coef_c !== want.coef_c) begin
                    $error("coef_c: expected %0d, got %0d", want.coef_c, m_data.coef_c);
                    error_count++;
                end
                if (m_data.coef_d !== want.coef_d) begin
                    $error("coef_d: expected %0d, got %0d", want.coef_d, m_data.coef_d);
                    error_count++;
                end
                if (m_data.status !== want.status) begin
                    $error("status: expected %0b, got %0b", want.status, m_data.status);
                    error_count++;
                end
            end
        end
    end

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_streaming();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idling();
        test_backpressure();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_bases.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
